// ----- hdl/atd_pkg.sv -----
// shared types, constants and codes for the activation table with decay
// no dependencies; every other file but atd_ram imports this package
`timescale 1ns / 1ps

package atd_pkg;

  // table geometry
  localparam int Depth = 64;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  // field widths
  localparam int KeyW    = 32;
  localparam int LvlW    = 17;
  localparam int TurnW   = 32;
  localparam int DecW    = 16;
  localparam int ModeW   = 2;
  localparam int StatW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 17;

  // fixed point constants, q.16
  localparam logic [LvlW-1:0] LevelOne      = 17'd65536;
  localparam logic [DecW-1:0] DecayDefault  = 16'd55706;
  localparam logic [LvlW-1:0] ThreshDefault = 17'd6554;

  // item modes
  localparam logic [ModeW-1:0] ModeStim  = 2'd0;
  localparam logic [ModeW-1:0] ModeTick  = 2'd1;
  localparam logic [ModeW-1:0] ModeQuery = 2'd2;

  // result status codes
  localparam logic [StatW-1:0] StIgnored  = 3'd0;
  localparam logic [StatW-1:0] StAdded    = 3'd1;
  localparam logic [StatW-1:0] StInserted = 3'd2;
  localparam logic [StatW-1:0] StReplaced = 3'd3;
  localparam logic [StatW-1:0] StRejected = 3'd4;
  localparam logic [StatW-1:0] StTicked   = 3'd5;
  localparam logic [StatW-1:0] StHit      = 3'd6;
  localparam logic [StatW-1:0] StMiss     = 3'd7;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDecay  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgThresh = 2'd1;

  // one table entry as stored in memory
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [LvlW-1:0]  level;
    logic [TurnW-1:0] turn;
  } entry_t;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [DecW-1:0] decay;
    logic [LvlW-1:0] thresh;
  } cfg_t;

  // memory access request from the sequencer
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

  // one result beat
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [LvlW-1:0]  level;
    logic [TurnW-1:0] turn;
    logic [CntW-1:0]  live;
  } result_t;

endpackage

// ----- hdl/atd_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module atd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/atd_ctrl.sv -----
// sequencer and datapath: scans the entry memory for search, min and decay/compaction
// depends on atd_pkg; drives one atd_ram through a ram_req_t
`timescale 1ns / 1ps

module atd_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [atd_pkg::ModeW-1:0] mode_i,
  input  logic [atd_pkg::KeyW-1:0]  symbol_i,
  input  logic [atd_pkg::LvlW-1:0]  energy_i,
  input  atd_pkg::cfg_t            cfg_i,
  output atd_pkg::ram_req_t        ram_req_o,
  input  atd_pkg::entry_t          ram_rdata_i,
  output logic                     done_o,
  output atd_pkg::result_t         result_o
);

  import atd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StTick = 2'd2;

  // control state
  logic [1:0]       state_q, state_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [TurnW-1:0] turn_q, turn_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             rv_q, rv_d;
  logic             pv_q, pv_d;
  logic [CntW-1:0]  w_q, w_d;
  logic             found_q, found_d;
  logic             minv_q, minv_d;

  // payload state
  logic [ModeW-1:0] mode_q, mode_d;
  logic [KeyW-1:0]  sym_q, sym_d;
  logic [LvlW-1:0]  energy_q, energy_d;
  logic [IdxW-1:0]  rv_idx_q, rv_idx_d;
  logic [IdxW-1:0]  found_idx_q, found_idx_d;
  logic [LvlW-1:0]  found_lvl_q, found_lvl_d;
  logic [TurnW-1:0] found_turn_q, found_turn_d;
  logic [IdxW-1:0]  min_idx_q, min_idx_d;
  logic [LvlW-1:0]  min_lvl_q, min_lvl_d;
  logic [LvlW-1:0]  pnv_q, pnv_d;
  logic [KeyW-1:0]  pkey_q, pkey_d;
  logic [TurnW-1:0] pturn_q, pturn_d;
  result_t          res_q, res_d;

  logic                 issue;
  logic                 accept;
  logic [LvlW+DecW-1:0] prod;
  logic [LvlW:0]        sum;
  logic [LvlW-1:0]      added;
  logic [LvlW-1:0]      clipped;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  // memory issue: one read a cycle while entries remain below the fill count
  assign issue = (state_q != StIdle) && (rd_idx_q < count_q);

  // decay product on the registered read data
  assign prod = ram_rdata_i.level * cfg_i.decay;

  // saturating add and clipped insert value
  assign sum     = {1'b0, found_lvl_q} + {1'b0, energy_q};
  assign added   = (sum > {1'b0, LevelOne}) ? LevelOne : sum[LvlW-1:0];
  assign clipped = (energy_q > LevelOne) ? LevelOne : energy_q;

  always_comb begin
    state_d      = state_q;
    done_d       = 1'b0;
    count_d      = count_q;
    turn_d       = turn_q;
    rd_idx_d     = rd_idx_q;
    rv_d         = issue;
    rv_idx_d     = rd_idx_q[IdxW-1:0];
    pv_d         = 1'b0;
    w_d          = w_q;
    found_d      = found_q;
    minv_d       = minv_q;
    mode_d       = mode_q;
    sym_d        = sym_q;
    energy_d     = energy_q;
    found_idx_d  = found_idx_q;
    found_lvl_d  = found_lvl_q;
    found_turn_d = found_turn_q;
    min_idx_d    = min_idx_q;
    min_lvl_d    = min_lvl_q;
    pnv_d        = pnv_q;
    pkey_d       = pkey_q;
    pturn_d      = pturn_q;
    res_d        = res_q;

    ram_req_o       = '0;
    ram_req_o.raddr = rd_idx_q[IdxW-1:0];

    if (issue) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end

    unique case (state_q)
      // take a new item
      StIdle: begin
        if (accept) begin
          mode_d   = mode_i;
          sym_d    = symbol_i;
          energy_d = energy_i;
          rd_idx_d = '0;
          w_d      = '0;
          found_d  = 1'b0;
          minv_d   = 1'b0;
          unique case (mode_i)
            ModeStim: begin
              if (symbol_i == '0 || energy_i == '0) begin
                done_d = 1'b1;
                res_d  = '{StIgnored, '0, turn_q, count_q};
              end else begin
                state_d = StScan;
              end
            end
            ModeTick: begin
              turn_d  = turn_q + 1'b1;
              state_d = StTick;
            end
            ModeQuery: begin
              if (symbol_i == '0) begin
                done_d = 1'b1;
                res_d  = '{StMiss, '0, turn_q, count_q};
              end else begin
                state_d = StScan;
              end
            end
            default: begin
              done_d = 1'b1;
              res_d  = '{StIgnored, '0, turn_q, count_q};
            end
          endcase
        end
      end

      // key search and first-lowest tracking, then at most one write-back (none for a query or a rejection)
      StScan: begin
        if (rv_q) begin
          if (!found_q && ram_rdata_i.key == sym_q) begin
            found_d      = 1'b1;
            found_idx_d  = rv_idx_q;
            found_lvl_d  = ram_rdata_i.level;
            found_turn_d = ram_rdata_i.turn;
          end
          if (!minv_q || ram_rdata_i.level < min_lvl_q) begin
            minv_d    = 1'b1;
            min_idx_d = rv_idx_q;
            min_lvl_d = ram_rdata_i.level;
          end
        end
        // all reads drained, so the write cannot overlap a pending read
        if (rd_idx_q == count_q && !rv_q) begin
          state_d = StIdle;
          done_d  = 1'b1;
          if (mode_q == ModeQuery) begin
            if (found_q) begin
              res_d = '{StHit, found_lvl_q, found_turn_q, count_q};
            end else begin
              res_d = '{StMiss, '0, turn_q, count_q};
            end
          end else if (found_q) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = found_idx_q;
            ram_req_o.wdata = '{sym_q, added, turn_q};
            res_d           = '{StAdded, added, turn_q, count_q};
          end else if (count_q < CntW'(Depth)) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = count_q[IdxW-1:0];
            ram_req_o.wdata = '{sym_q, clipped, turn_q};
            count_d         = count_q + 1'b1;
            res_d           = '{StInserted, clipped, turn_q, count_q + 1'b1};
          end else if (energy_q > min_lvl_q) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = min_idx_q;
            ram_req_o.wdata = '{sym_q, clipped, turn_q};
            res_d           = '{StReplaced, clipped, turn_q, count_q};
          end else begin
            res_d = '{StRejected, '0, turn_q, count_q};
          end
        end
      end

      // decay and compaction: read i, multiply, write survivor at w (w never passes i)
      StTick: begin
        if (rv_q) begin
          pv_d    = 1'b1;
          pnv_d   = prod[LvlW+DecW-1:DecW];
          pkey_d  = ram_rdata_i.key;
          pturn_d = ram_rdata_i.turn;
        end
        if (pv_q && pnv_q >= cfg_i.thresh) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = w_q[IdxW-1:0];
          ram_req_o.wdata = '{pkey_q, pnv_q, pturn_q};
          w_d             = w_q + 1'b1;
        end
        if (rd_idx_q == count_q && !rv_q && !pv_q) begin
          state_d = StIdle;
          done_d  = 1'b1;
          count_d = w_q;
          res_d   = '{StTicked, '0, turn_q, w_q};
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      done_q   <= 1'b0;
      count_q  <= '0;
      turn_q   <= '0;
      rd_idx_q <= '0;
      rv_q     <= 1'b0;
      pv_q     <= 1'b0;
      w_q      <= '0;
      found_q  <= 1'b0;
      minv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      count_q  <= count_d;
      turn_q   <= turn_d;
      rd_idx_q <= rd_idx_d;
      rv_q     <= rv_d;
      pv_q     <= pv_d;
      w_q      <= w_d;
      found_q  <= found_d;
      minv_q   <= minv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    sym_q        <= sym_d;
    energy_q     <= energy_d;
    rv_idx_q     <= rv_idx_d;
    found_idx_q  <= found_idx_d;
    found_lvl_q  <= found_lvl_d;
    found_turn_q <= found_turn_d;
    min_idx_q    <= min_idx_d;
    min_lvl_q    <= min_lvl_d;
    pnv_q        <= pnv_d;
    pkey_q       <= pkey_d;
    pturn_q      <= pturn_d;
    res_q        <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // fill count never exceeds the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count above table depth");

  // a result beat only follows the end of an item
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == StIdle)
    else $error("result beat while sequencer busy");

  // compaction writes stay behind the read pointer
  a_tick_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTick && ram_req_o.we) |-> (w_q < rd_idx_q))
    else $error("compaction write overtakes read");

  // no memory write while a scan read is still in flight
  a_scan_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && ram_req_o.we) |-> (!rv_q && rd_idx_q == count_q))
    else $error("scan write-back overlaps pending read");

  // an accepted item ends in exactly one state change or an immediate beat
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_q || busy_o))
    else $error("accepted item neither started nor answered");

endmodule

// ----- hdl/activation_table_with_decay_core.sv -----
// top level: configuration registers, entry memory and sequencer
// depends on atd_pkg, atd_ram and atd_ctrl
// ignored items and zero-key queries are answered straight from idle; a search or a tick
//   makes one ram read a cycle over the live entries, then the read and decay stages drain
// throughput: one item at a time, a new start is taken in the cycle done_o is high
// reset: table empty and turn counter zero at once, no clearing pass; registers to defaults
`timescale 1ns / 1ps

module activation_table_with_decay_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [atd_pkg::ModeW-1:0]   mode_i,
  input  logic [atd_pkg::KeyW-1:0]    symbol_i,
  input  logic [atd_pkg::LvlW-1:0]    energy_i,
  output logic                        done_o,
  output logic [atd_pkg::StatW-1:0]   status_o,
  output logic [atd_pkg::LvlW-1:0]    level_o,
  output logic [atd_pkg::TurnW-1:0]   touched_turn_o,
  output logic [atd_pkg::CntW-1:0]    live_entries_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [atd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [atd_pkg::CfgW-1:0]    cfg_data_i
);

  import atd_pkg::*;

  logic [DecW-1:0] decay_q;
  logic [LvlW-1:0] thresh_q;
  cfg_t            cfg;
  ram_req_t        ram_req;
  entry_t          ram_rdata;
  result_t         result;

  assign cfg_ready_o = 1'b1;

  // configuration beats; zero selects the default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q  <= DecayDefault;
      thresh_q <= ThreshDefault;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgDecay: begin
          decay_q <= (cfg_data_i[DecW-1:0] == '0) ? DecayDefault : cfg_data_i[DecW-1:0];
        end
        CfgThresh: begin
          thresh_q <= (cfg_data_i[LvlW-1:0] == '0) ? ThreshDefault : cfg_data_i[LvlW-1:0];
        end
        default: begin
          decay_q <= decay_q;
        end
      endcase
    end
  end

  assign cfg.decay  = decay_q;
  assign cfg.thresh = thresh_q;

  // entry memory
  atd_ram #(
    .Width($bits(entry_t)),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_req.we),
    .waddr_i(ram_req.waddr),
    .wdata_i(ram_req.wdata),
    .raddr_i(ram_req.raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer
  atd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .mode_i     (mode_i),
    .symbol_i   (symbol_i),
    .energy_i   (energy_i),
    .cfg_i      (cfg),
    .ram_req_o  (ram_req),
    .ram_rdata_i(ram_rdata),
    .done_o     (done_o),
    .result_o   (result)
  );

  // result beat fields
  assign status_o       = result.status;
  assign level_o        = result.level;
  assign touched_turn_o = result.turn;
  assign live_entries_o = result.live;

endmodule

// ----- bench/activation_table_with_decay_checker.sv -----
// checker for the activation table core: shadow table, expected answers and compare
// depends on atd_pkg; sits beside the core in the testbench top and only watches
`timescale 1ns / 1ps

module activation_table_with_decay_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [atd_pkg::ModeW-1:0]   mode_i,
  input  logic [atd_pkg::KeyW-1:0]    symbol_i,
  input  logic [atd_pkg::LvlW-1:0]    energy_i,
  input  logic                        done_i,
  input  logic [atd_pkg::StatW-1:0]   status_i,
  input  logic [atd_pkg::LvlW-1:0]    level_i,
  input  logic [atd_pkg::TurnW-1:0]   turn_i,
  input  logic [atd_pkg::CntW-1:0]    live_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [atd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [atd_pkg::CfgW-1:0]    cfg_data_i,
  output int                          errors_o,
  output int                          pending_o,
  output int                          results_o,
  output logic [7:0]                  status_seen_o
);

  import atd_pkg::*;

  localparam int Frac = 16;

  // shadow copy of the table, counters and registers
  entry_t          shadow [Depth];
  logic [CntW-1:0] shadow_count;
  logic [TurnW-1:0] shadow_turn;
  logic [DecW-1:0] decay_q;
  logic [LvlW-1:0] thresh_q;

  // answers owed by the core, oldest first
  result_t answer_q [$];

  function automatic int find_entry(logic [KeyW-1:0] key);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow[i].key == key) return i;
    end
    return -1;
  endfunction

  // apply one item to the shadow table and return the answer it should give
  function automatic result_t apply_item(logic [ModeW-1:0] mode, logic [KeyW-1:0] key,
                                         logic [LvlW-1:0] energy);
    result_t              r;
    int                   hit;
    int                   low_i;
    int                   kept;
    logic [LvlW-1:0]      clipped;
    logic [LvlW:0]        sum;
    logic [LvlW+DecW-1:0] prod;
    clipped  = (energy > LevelOne) ? LevelOne : energy;
    r.status = StIgnored;
    r.level  = '0;
    r.turn   = shadow_turn;
    case (mode)
      ModeStim: begin
        if (key != '0 && energy != '0) begin
          hit = find_entry(key);
          if (hit >= 0) begin
            // add to a live key, saturate at one
            sum = shadow[hit].level + energy;
            shadow[hit].level = (sum > LevelOne) ? LevelOne : sum[LvlW-1:0];
            shadow[hit].turn  = shadow_turn;
            r.status = StAdded;
            r.level  = shadow[hit].level;
          end else if (shadow_count < Depth) begin
            // append while there is room
            shadow[shadow_count].key   = key;
            shadow[shadow_count].level = clipped;
            shadow[shadow_count].turn  = shadow_turn;
            shadow_count++;
            r.status = StInserted;
            r.level  = clipped;
          end else begin
            // full: first entry with the lowest level may be evicted
            low_i = 0;
            for (int i = 1; i < Depth; i++) begin
              if (shadow[i].level < shadow[low_i].level) low_i = i;
            end
            if (energy > shadow[low_i].level) begin
              shadow[low_i].key   = key;
              shadow[low_i].level = clipped;
              shadow[low_i].turn  = shadow_turn;
              r.status = StReplaced;
              r.level  = clipped;
            end else begin
              r.status = StRejected;
            end
          end
        end
      end
      ModeTick: begin
        // decay every level, drop the weak ones, keep survivor order
        shadow_turn++;
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          prod = shadow[i].level * decay_q;
          if (prod[LvlW+DecW-1:Frac] >= thresh_q) begin
            shadow[kept]       = shadow[i];
            shadow[kept].level = prod[LvlW+DecW-1:Frac];
            kept++;
          end
        end
        shadow_count = kept[CntW-1:0];
        r.status = StTicked;
        r.turn   = shadow_turn;
      end
      ModeQuery: begin
        hit = (key == '0) ? -1 : find_entry(key);
        if (hit >= 0) begin
          r.status = StHit;
          r.level  = shadow[hit].level;
          r.turn   = shadow[hit].turn;
        end else begin
          r.status = StMiss;
        end
      end
      default: ;
    endcase
    r.live = shadow_count;
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors_o++;
    end
  endtask

  // compare result beats first, then take config and item beats of the same edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) shadow[i] = '0;
      shadow_count  = '0;
      shadow_turn   = '0;
      decay_q       = DecayDefault;
      thresh_q      = ThreshDefault;
      answer_q.delete();
      errors_o      = 0;
      pending_o     = 0;
      results_o     = 0;
      status_seen_o = '0;
    end else begin
      if (done_i) begin
        results_o++;
        status_seen_o[status_i] = 1'b1;
        if (answer_q.size() == 0) begin
          $display("%0t: result beat with nothing awaited: status %0d level %0d",
                   $time, status_i, level_i);
          errors_o++;
        end else begin
          want = answer_q.pop_front();
          check_field("status", want.status, status_i);
          check_field("level", want.level, level_i);
          check_field("touched_turn", want.turn, turn_i);
          check_field("live_entries", want.live, live_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        // zero written to either register falls back to its default
        case (cfg_index_i)
          CfgDecay:  decay_q = (cfg_data_i[DecW-1:0] == '0) ? DecayDefault
                                                            : cfg_data_i[DecW-1:0];
          CfgThresh: thresh_q = (cfg_data_i == '0) ? ThreshDefault : cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        answer_q.push_back(apply_item(mode_i, symbol_i, energy_i));
      end
      pending_o = answer_q.size();
    end
  end

endmodule

// ----- bench/activation_table_with_decay_core_tb.sv -----
// testbench top for the activation table core: clock, reset, stimulus and verdict
// depends on atd_pkg, the core and activation_table_with_decay_checker
`timescale 1ns / 1ps

module activation_table_with_decay_core_tb;
  import atd_pkg::*;

  localparam logic [ModeW-1:0] ModeSpare = 2'd3;
  localparam int PoolSize = 96;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start_i     = 1'b0;
  logic [ModeW-1:0]   mode_i      = '0;
  logic [KeyW-1:0]    symbol_i    = '0;
  logic [LvlW-1:0]    energy_i    = '0;
  logic               cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;
  logic               busy_o;
  logic               done_o;
  logic [StatW-1:0]   status_o;
  logic [LvlW-1:0]    level_o;
  logic [TurnW-1:0]   touched_turn_o;
  logic [CntW-1:0]    live_entries_o;
  logic               cfg_ready_o;

  int          errors;
  int          pending;
  int          results;
  logic [7:0]  status_seen;
  int          items_sent;
  int          settings_run;
  logic [KeyW-1:0] key_pool [PoolSize];

  activation_table_with_decay_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .symbol_i       (symbol_i),
    .energy_i       (energy_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .level_o        (level_o),
    .touched_turn_o (touched_turn_o),
    .live_entries_o (live_entries_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  activation_table_with_decay_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .mode_i        (mode_i),
    .symbol_i      (symbol_i),
    .energy_i      (energy_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .level_i       (level_o),
    .turn_i        (touched_turn_o),
    .live_i        (live_entries_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending),
    .results_o     (results),
    .status_seen_o (status_seen)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // hold start until the core takes the beat; returns on the accepting edge
  task automatic send_item(logic [ModeW-1:0] mode, logic [KeyW-1:0] key,
                           logic [LvlW-1:0] energy);
    start_i  <= 1'b1;
    mode_i   <= mode;
    symbol_i <= key;
    energy_i <= energy;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    items_sent++;
  endtask

  // drop start for a short or, now and then, a long gap
  task automatic take_break();
    start_i <= 1'b0;
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 70)) @(posedge clk_i);
    else repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // wait until every answer owed has come back
  task automatic settle();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    repeat ($urandom_range(1, 3)) @(posedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] pick_key(int span);
    if ($urandom_range(0, 99) < 12) return $urandom();
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  function automatic logic [LvlW-1:0] pick_energy();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return '1;
    if (roll < 8) return LevelOne;
    if (roll < 12) return LvlW'(1);
    if (roll < 55) return LvlW'($urandom_range(1, 20000));
    return LvlW'($urandom_range(1, 131071));
  endfunction

  // one register setting followed by a burst of mostly well-formed traffic
  task automatic run_phase(logic [CfgW-1:0] decay, logic [CfgW-1:0] thresh, int span,
                           int tick_pct, int count, bit no_idle);
    int roll;
    settle();
    write_reg(CfgDecay, decay);
    write_reg(CfgThresh, thresh);
    settings_run++;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // noise: spare mode, invalid key, zero energy, invalid query
        case ($urandom_range(0, 3))
          0: send_item(ModeSpare, $urandom(), LvlW'($urandom()));
          1: send_item(ModeStim, '0, pick_energy());
          2: send_item(ModeStim, pick_key(span), '0);
          default: send_item(ModeQuery, '0, LvlW'($urandom()));
        endcase
      end else if (roll < 5 + tick_pct) begin
        send_item(ModeTick, $urandom(), LvlW'($urandom()));
      end else if (roll < 25 + tick_pct) begin
        send_item(ModeQuery, pick_key(span), LvlW'($urandom()));
      end else begin
        send_item(ModeStim, pick_key(span), pick_energy());
      end
      if (!no_idle && $urandom_range(0, 99) < 24) take_break();
    end
  endtask

  // reset and stimulus
  initial begin
    items_sent   = 0;
    settings_run = 0;
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = $urandom();
      if (key_pool[i] == '0) key_pool[i] = i + 1;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, ignored cases, saturation, compaction, turn tracking
    send_item(ModeQuery, 32'd5, '0);
    send_item(ModeStim, '0, 17'd100);
    send_item(ModeStim, 32'd5, '0);
    send_item(ModeSpare, 32'd5, 17'd100);
    send_item(ModeStim, 32'd5, '1);
    send_item(ModeStim, 32'd5, 17'd1);
    send_item(ModeStim, '1, LevelOne);
    send_item(ModeStim, 32'd9, 17'd6000);
    send_item(ModeStim, 32'd7, 17'd1);
    send_item(ModeStim, 32'd7, 17'd30000);
    send_item(ModeQuery, '0, '1);
    send_item(ModeQuery, 32'd5, '0);
    send_item(ModeQuery, '1, '0);
    send_item(ModeTick, '0, '0);
    send_item(ModeQuery, 32'd9, '0);
    send_item(ModeQuery, 32'd7, '0);
    send_item(ModeStim, 32'd7, 17'd10);
    send_item(ModeQuery, 32'd7, '0);
    send_item(ModeTick, '1, '1);
    send_item(ModeQuery, '1, '0);
    send_item(ModeStim, 32'h8000_0000, 17'h10000);
    send_item(ModeStim, 32'h8000_0000, 17'h0FFFF);

    // zero writes fall back to defaults; a slow decay fills the table for evictions
    run_phase('0, '0, 24, 12, 130, 1'b0);
    run_phase(17'h1FFFF, 17'd1, PoolSize, 2, 200, 1'b1);
    run_phase(17'd1, LevelOne, 40, 10, 100, 1'b0);
    run_phase(17'd32768, 17'd20000, 48, 8, 130, 1'b0);
    run_phase(17'd60000, '1, 24, 10, 80, 1'b0);
    run_phase(CfgW'($urandom_range(1, 65535)), CfgW'($urandom_range(1, 65536)), PoolSize,
              4, 190, 1'b0);

    settle();
    repeat (80) @(posedge clk_i);
    $display("%0d items over %0d register settings, %0d results checked", items_sent,
             settings_run, results);
    $display("status codes seen (bit per code): %b", status_seen);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- activation_table_with_decay_core.f -----
hdl/atd_pkg.sv
hdl/atd_ram.sv
hdl/atd_ctrl.sv
hdl/activation_table_with_decay_core.sv
bench/activation_table_with_decay_checker.sv
bench/activation_table_with_decay_core_tb.sv
